### hdl/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// No dependencies; imported by every module of the block.
package bsa_pkg;

  localparam int unsigned MaxSlotsDefault = 32;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned TagW    = 32;
  localparam int unsigned SizeW   = 25;
  localparam int unsigned CountW  = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  localparam logic [CfgIdxW-1:0] CfgBase  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSize  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCount = 2'd2;

  localparam logic [SizeW-1:0]  SizeReset  = 25'd16;
  localparam logic [CountW-1:0] CountReset = 6'd32;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_UNUSED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_FULL   = 2'd1,
    EV_REJOIN = 2'd2,
    EV_EMPTY  = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_ADD,
    S_DIV,
    S_READ
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] slot_address;
    logic [TagW-1:0]  owner;
    status_e          status;
    event_e           list_event;
    logic             chunk_empty;
  } result_t;

endpackage

### hdl/bitmap_slot_allocator.sv
// Top level of the bitmap slot allocator: config registers, sequencer,
// used bitmap and occupancy. Depends on bsa_pkg, bsa_div and bsa_owner_ram.
//
//   channel   | signals                                   | flow
//   ----------+-------------------------------------------+-----------------
//   command   | start_i, busy_o, command_i, address_i,    | accepted when
//             | owner_tag_i                               | start_i & !busy_o
//   result    | done_o, slot_address_o, owner_out_o,      | one-cycle strobe
//             | status_o, list_event_o, chunk_empty_o     |
//   config    | cfg_we_i, cfg_index_i, cfg_data_i         | write on cfg_we_i
//
// Steps per beat, from accept to strobe:
//   allocate: scan k+1 slots one per cycle (k = slots skipped), then a
//             multiply step and an add step.
//             A chunk already full answers without a scan.
//   free / lookup: the shared divider turns the offset into a slot index
//             (load, then 32 quotient bits); free then answers, lookup
//             first reads the owner RAM.
//   unused command code: answers straight from idle.
// busy_o stays high until the result register is loaded; the strobe cycle
// overlaps the next accept. Reset clears the bitmap, pointer and occupancy and
// loads the config defaults; the owner RAM needs no clearing since it is only
// read for used slots.
// The receiver cannot stall: a result is held for exactly one cycle.
module bitmap_slot_allocator #(
  parameter int unsigned MAX_SLOTS = bsa_pkg::MaxSlotsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command beat
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  command_i,
  input  logic [bsa_pkg::AddrW-1:0]   address_i,
  input  logic [bsa_pkg::TagW-1:0]    owner_tag_i,
  // result beat
  output logic                        done_o,
  output logic [bsa_pkg::AddrW-1:0]   slot_address_o,
  output logic [bsa_pkg::TagW-1:0]    owner_out_o,
  output logic [1:0]                  status_o,
  output logic [1:0]                  list_event_o,
  output logic                        chunk_empty_o,
  // config writes
  input  logic                        cfg_we_i,
  input  logic [bsa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bsa_pkg::CfgW-1:0]    cfg_data_i
);
  import bsa_pkg::*;

  localparam int unsigned IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SLOTS + 1);

  // config
  logic [AddrW-1:0]  base_q;
  logic [SizeW-1:0]  size_q;
  logic [CountW-1:0] count_q;

  // allocator state
  state_e            state_q, state_d;
  logic [MAX_SLOTS-1:0] used_q, used_d;
  logic [IdxW-1:0]   sp_q, sp_d;
  logic [CntW-1:0]   occ_q, occ_d;

  // per-beat working registers
  cmd_e              cmd_q, cmd_d;
  logic [TagW-1:0]   tag_q, tag_d;
  logic [IdxW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   seen_q, seen_d;
  logic [AddrW-1:0]  prod_q, prod_d;
  result_t           res_q, res_d;
  logic              done_q, done_d;

  // derived values
  logic [SizeW-1:0]  grain;
  logic [CntW-1:0]   n_eff;
  logic [CountW:0]   count_ext;
  logic              accept;
  logic [CntW-1:0]   occ_dec;
  logic [CntW-1:0]   ptr_ext;

  // divider and RAM hookup
  logic              div_start;
  logic              div_done;
  logic [AddrW-1:0]  div_quot;
  logic [IdxW-1:0]   q_idx;
  logic              ram_we;
  logic              ram_re;
  logic [TagW-1:0]   ram_rdata;

  // zero grain acts as one; slot count clamps to 1..MAX_SLOTS
  assign grain     = (size_q == '0) ? SizeW'(1) : size_q;
  assign count_ext = {1'b0, count_q};
  always_comb begin
    if (count_q == '0) begin
      n_eff = CntW'(1);
    end else if (count_ext > (CountW + 1)'(MAX_SLOTS)) begin
      n_eff = CntW'(MAX_SLOTS);
    end else begin
      n_eff = CntW'(count_q);
    end
  end

  assign accept    = start_i && (state_q == S_IDLE);
  assign div_start = accept && ((cmd_e'(command_i) == CMD_FREE) ||
                                (cmd_e'(command_i) == CMD_LOOKUP));
  assign q_idx     = div_quot[IdxW-1:0];
  assign occ_dec   = (occ_q == '0) ? '0 : occ_q - 1'b1;
  assign ptr_ext   = CntW'(ptr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      size_q  <= SizeReset;
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgBase:  base_q  <= cfg_data_i[AddrW-1:0];
        CfgSize:  size_q  <= cfg_data_i[SizeW-1:0];
        CfgCount: count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    sp_d    = sp_q;
    occ_d   = occ_q;
    cmd_d   = cmd_q;
    tag_d   = tag_q;
    ptr_d   = ptr_q;
    seen_d  = seen_q;
    prod_d  = prod_q;
    res_d   = res_q;
    done_d  = 1'b0;
    ram_we  = 1'b0;
    ram_re  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d = cmd_e'(command_i);
          tag_d = owner_tag_i;
          res_d = '0;
          case (cmd_e'(command_i))
            CMD_ALLOC: begin
              if (occ_q >= n_eff) begin
                res_d.status = STAT_FULL;
                done_d       = 1'b1;
              end else begin
                ptr_d   = (CntW'(sp_q) < n_eff) ? sp_q : '0;
                seen_d  = '0;
                state_d = S_SCAN;
              end
            end
            CMD_FREE, CMD_LOOKUP: state_d = S_DIV;
            default: done_d = 1'b1;
          endcase
        end
      end

      // next-fit scan, one slot per cycle with wrap at the slot count
      S_SCAN: begin
        if (!used_q[ptr_q]) begin
          state_d = S_MUL;
        end else if (seen_q == n_eff - 1'b1) begin
          res_d.status = STAT_FULL;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          seen_d = seen_q + 1'b1;
          ptr_d  = (ptr_ext + 1'b1 == n_eff) ? '0 : ptr_q + 1'b1;
        end
      end

      S_MUL: begin
        prod_d         = AddrW'(grain) * AddrW'(ptr_q);
        used_d[ptr_q]  = 1'b1;
        sp_d           = ptr_q;
        occ_d          = occ_q + 1'b1;
        ram_we         = 1'b1;
        if ((occ_q + 1'b1 == n_eff) && (n_eff > CntW'(1))) begin
          res_d.list_event = EV_FULL;
        end
        state_d = S_ADD;
      end

      S_ADD: begin
        res_d.slot_address = base_q + prod_q;
        done_d             = 1'b1;
        state_d            = S_IDLE;
      end

      S_DIV: begin
        if (div_done) begin
          if (div_quot >= AddrW'(n_eff)) begin
            res_d.status = STAT_RANGE;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end else if (!used_q[q_idx]) begin
            res_d.status = STAT_UNUSED;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end else if (cmd_q == CMD_LOOKUP) begin
            ram_re  = 1'b1;
            state_d = S_READ;
          end else begin
            used_d[q_idx] = 1'b0;
            occ_d         = occ_dec;
            if ((occ_q == n_eff) && (n_eff > CntW'(1))) begin
              res_d.list_event = EV_REJOIN;
            end
            if (occ_dec == '0) begin
              res_d.chunk_empty = 1'b1;
              if (n_eff > CntW'(1)) begin
                res_d.list_event = EV_EMPTY;
              end
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end

      S_READ: begin
        res_d.owner = ram_rdata;
        done_d      = 1'b1;
        state_d     = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      sp_q    <= '0;
      occ_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      sp_q    <= sp_d;
      occ_q   <= occ_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    tag_q  <= tag_d;
    ptr_q  <= ptr_d;
    seen_q <= seen_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  // offset / grain; an address below base wraps to a large offset
  bsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (address_i - base_q),
    .divisor_i  (grain),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  bsa_owner_ram #(
    .Depth (MAX_SLOTS),
    .IdxW  (IdxW)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (tag_q),
    .re_i    (ram_re),
    .raddr_i (q_idx),
    .rdata_o (ram_rdata)
  );

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign slot_address_o = res_q.slot_address;
  assign owner_out_o    = res_q.owner;
  assign status_o       = res_q.status;
  assign list_event_o   = res_q.list_event;
  assign chunk_empty_o  = res_q.chunk_empty;

endmodule

### hdl/bsa_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on bsa_pkg for operand widths.
module bsa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bsa_pkg::AddrW-1:0] dividend_i,
  input  logic [bsa_pkg::SizeW-1:0] divisor_i,
  output logic                      done_o,
  output logic [bsa_pkg::AddrW-1:0] quotient_o
);
  import bsa_pkg::*;

  localparam int unsigned StepW = $clog2(AddrW);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [AddrW-1:0] quot_q, quot_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [SizeW-1:0] dvs_q, dvs_d;
  logic [SizeW:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q, quot_q[AddrW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (run_q) begin
      quot_d = {quot_q[AddrW-2:0], ge};
      rem_d  = ge ? SizeW'(rem_sh - {1'b0, dvs_q}) : rem_sh[SizeW-1:0];
      step_d = step_q + 1'b1;
      if (step_q == StepW'(AddrW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

### hdl/bsa_owner_ram.sv
// Owner tag store: one write port, one registered read port.
// Depends on bsa_pkg for the tag width.
module bsa_owner_ram #(
  parameter int unsigned Depth = bsa_pkg::MaxSlotsDefault,
  parameter int unsigned IdxW  = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [IdxW-1:0]          waddr_i,
  input  logic [bsa_pkg::TagW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [IdxW-1:0]          raddr_i,
  output logic [bsa_pkg::TagW-1:0] rdata_o
);
  import bsa_pkg::*;

  logic [TagW-1:0] mem [Depth];
  logic [TagW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/testbench.sv
// Self-checking testbench for bitmap_slot_allocator: directed table, then random phases.
// Depends on bsa_pkg and hdl/ RTL; checks every reply against an in-bench model or typed want.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bsa_pkg::*;

  localparam int SLOTS       = MaxSlotsDefault;
  localparam int RandomItems = 1700;
  localparam int PhaseItems  = 150;
  localparam int StallLimit  = 1000;  // idle cycles before the watchdog trips
  localparam int TailCycles  = 40;    // longer than the longest beat
  localparam int PrintCap    = 100;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic [1:0]          command_i   = CMD_NONE;
  logic [AddrW-1:0]    address_i   = '0;
  logic [TagW-1:0]     owner_tag_i = '0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgBase;
  logic [CfgW-1:0]     cfg_data_i  = '0;

  logic                busy_o;
  logic                done_o;
  logic [AddrW-1:0]    slot_address_o;
  logic [TagW-1:0]     owner_out_o;
  logic [1:0]          status_o;
  logic [1:0]          list_event_o;
  logic                chunk_empty_o;

  always #1 clk_i = ~clk_i;

  bitmap_slot_allocator #(
    .MAX_SLOTS(SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .address_i     (address_i),
    .owner_tag_i   (owner_tag_i),
    .done_o        (done_o),
    .slot_address_o(slot_address_o),
    .owner_out_o   (owner_out_o),
    .status_o      (status_o),
    .list_event_o  (list_event_o),
    .chunk_empty_o (chunk_empty_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the chunk: registers and allocator state, at reset values.
  // ---------------------------------------------------------------------------
  logic [AddrW-1:0]  reg_base  = '0;
  logic [SizeW-1:0]  reg_size  = SizeReset;
  logic [CountW-1:0] reg_count = CountReset;

  logic [SLOTS-1:0]  used_bits = '0;
  int                scan_ptr  = 0;
  int                occ       = 0;
  logic [TagW-1:0]   owners [SLOTS];

  initial foreach (owners[i]) owners[i] = '0;

  // Replies owed by the DUT, oldest first.
  result_t owed_replies [$];
  result_t owed_head;

  int errors     = 0;
  int n_alloc    = 0;
  int n_free     = 0;
  int n_lookup   = 0;
  int n_unused   = 0;
  int n_settings = 0;
  int n_replies  = 0;
  int n_fullev   = 0;
  int n_emptied  = 0;
  int stall_cycles = 0;

  // Slot count as the block uses it: zero means one, saturates at SLOTS.
  function automatic int live_count();
    int n;
    n = int'(reg_count);
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  // Allocation grain; a size of zero acts as one byte.
  function automatic logic [31:0] slot_grain();
    return (reg_size == '0) ? 32'd1 : {{(32-SizeW){1'b0}}, reg_size};
  endfunction

  // Apply one command to the shadow chunk and return the reply it must give.
  function automatic result_t apply_slot_op(cmd_e op, logic [31:0] addr, logic [31:0] tag);
    result_t     r;
    int          n, p, k;
    bit          found;
    logic [31:0] grain, idx, pv;
    r     = '0;
    n     = live_count();
    grain = slot_grain();
    idx   = (addr - reg_base) / grain;  // below base wraps to a huge offset
    case (op)
      CMD_ALLOC: begin
        if (occ >= n) begin
          r.status = STAT_FULL;
        end else begin
          // next fit: start at the pointer, or slot 0 if it is past the count
          p     = (scan_ptr < n) ? scan_ptr : 0;
          found = 1'b0;
          for (k = 0; k < n; k++) begin
            if (!found) begin
              if (!used_bits[p]) found = 1'b1;
              else p = (p + 1) % n;
            end
          end
          if (!found) begin
            r.status = STAT_FULL;
          end else begin
            scan_ptr     = p;
            occ          = occ + 1;
            owners[p]    = tag;
            used_bits[p] = 1'b1;
            pv           = p;
            r.slot_address = reg_base + grain * pv;
            if (occ == n && n > 1) r.list_event = EV_FULL;
          end
        end
      end
      CMD_FREE, CMD_LOOKUP: begin
        if (idx >= n) begin
          r.status = STAT_RANGE;
        end else if (!used_bits[idx[4:0]]) begin
          r.status = STAT_UNUSED;
        end else if (op == CMD_LOOKUP) begin
          r.owner = owners[idx[4:0]];
        end else begin
          used_bits[idx[4:0]] = 1'b0;
          owners[idx[4:0]]    = '0;
          if (occ == n && n > 1) r.list_event = EV_REJOIN;
          if (occ > 0) occ = occ - 1;
          if (occ == 0) begin
            r.chunk_empty = 1'b1;
            if (n > 1) r.list_event = EV_EMPTY;
          end
        end
      end
      default: ;  // unused code: all-zero reply, no state change
    endcase
    return r;
  endfunction

  function automatic result_t reply(logic [31:0] a, logic [31:0] o, status_e s, event_e e,
                                    logic emp);
    result_t r;
    r.slot_address = a;
    r.owner        = o;
    r.status       = s;
    r.list_event   = e;
    r.chunk_empty  = emp;
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= PrintCap)
      $display("mismatch at reply %0d, %s: got %h, want %h", n_replies, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers. All run from posedge time steps and drive DUT inputs with NBAs only.

  // One command beat. start_i stays high across back-to-back beats (gap 0).
  task automatic send_beat(cmd_e op, logic [31:0] addr, logic [31:0] tag, bit typed,
                           result_t want, int gap);
    result_t model;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    command_i   <= op;
    address_i   <= addr;
    owner_tag_i <= tag;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    // accepted at this edge
    model = apply_slot_op(op, addr, tag);
    owed_replies.push_back(typed ? want : model);
    case (op)
      CMD_ALLOC:  n_alloc++;
      CMD_FREE:   n_free++;
      CMD_LOOKUP: n_lookup++;
      default:    n_unused++;
    endcase
  endtask

  // Wait until every reply is in; the block is idle after that.
  task automatic settle();
    start_i <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write; the enable is then driven low again before returning.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CfgBase:  reg_base  = value;
      CfgSize:  reg_size  = value[SizeW-1:0];
      CfgCount: reg_count = value[CountW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed traffic: allocations and frees/lookups of real slot
  // addresses, with some noise addresses and the unused command code.
  task automatic issue_random(int alloc_pct, int gap);
    int          n, roll, pick, i;
    int          live[$];
    logic [31:0] grain, a;
    cmd_e        op;
    n     = live_count();
    grain = slot_grain();
    roll  = $urandom_range(0, 99);
    a     = $urandom;
    if (roll < 4) begin
      op = CMD_NONE;
    end else if (roll < 12) begin
      op = ($urandom_range(0, 1) != 0) ? CMD_FREE : CMD_LOOKUP;
      if ($urandom_range(0, 1) != 0) a = reg_base - 32'd1 - $urandom_range(0, 255);
    end else if ($urandom_range(0, 99) < alloc_pct) begin
      op = CMD_ALLOC;
    end else begin
      op = ($urandom_range(0, 9) < 7) ? CMD_FREE : CMD_LOOKUP;
      for (i = 0; i < n; i++) if (used_bits[i]) live.push_back(i);
      pick = $urandom_range(0, 9);
      if (live.size() != 0 && pick < 8) pick = live[$urandom_range(0, live.size() - 1)];
      else if (pick == 9) pick = n;  // one slot past the end
      else pick = $urandom_range(0, n - 1);
      a = reg_base + grain * pick + $urandom_range(0, grain - 1);
    end
    send_beat(op, a, $urandom, 1'b0, '0, gap);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: register writes and beats. Rows with typed replies are
  // the obvious ones; the rest go through the shadow model.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                 is_cfg;
    logic [CfgIdxW-1:0] reg_idx;
    logic [31:0]        value;
    cmd_e               op;
    logic [31:0]        addr;
    logic [31:0]        tag;
    bit                 typed;
    result_t            want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic plan_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [31:0] value);
    plan_row_t r;
    r         = '{op: CMD_NONE, default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.value   = value;
    r.op      = CMD_NONE;
    return r;
  endfunction

  function automatic plan_row_t op_row(cmd_e op, logic [31:0] addr, logic [31:0] tag,
                                       bit typed, result_t want);
    plan_row_t r;
    r       = '{op: CMD_NONE, default: '0};
    r.op    = op;
    r.addr  = addr;
    r.tag   = tag;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  initial begin
    // reset config: base 0, 16-byte slots, 32 slots
    plan.push_back(op_row(CMD_LOOKUP, 32'h0, 32'h0, 1'b1,
                          reply(0, 0, STAT_UNUSED, EV_NONE, 1'b0)));
    plan.push_back(op_row(CMD_FREE, 32'h200, 32'h0, 1'b1,
                          reply(0, 0, STAT_RANGE, EV_NONE, 1'b0)));
    plan.push_back(op_row(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                          reply(0, 0, STAT_OK, EV_NONE, 1'b0)));
    plan.push_back(op_row(CMD_ALLOC, 32'h0, 32'hFFFF_FFFF, 1'b1,
                          reply(0, 0, STAT_OK, EV_NONE, 1'b0)));
    plan.push_back(op_row(CMD_ALLOC, 32'hFFFF_FFFF, 32'h0, 1'b1,
                          reply(16, 0, STAT_OK, EV_NONE, 1'b0)));
    plan.push_back(op_row(CMD_LOOKUP, 32'h0, 32'h0, 1'b1,
                          reply(0, 32'hFFFF_FFFF, STAT_OK, EV_NONE, 1'b0)));
    plan.push_back(op_row(CMD_FREE, 32'h1F, 32'h0, 1'b1,
                          reply(0, 0, STAT_OK, EV_NONE, 1'b0)));
    plan.push_back(op_row(CMD_FREE, 32'h1F, 32'h0, 1'b1,
                          reply(0, 0, STAT_UNUSED, EV_NONE, 1'b0)));
    plan.push_back(op_row(CMD_FREE, 32'h0, 32'h0, 1'b1,
                          reply(0, 0, STAT_OK, EV_EMPTY, 1'b1)));
    // count zero acts as one slot; the pointer (slot 1) is past it
    plan.push_back(cfg_row(CfgCount, 32'h0));
    plan.push_back(op_row(CMD_ALLOC, 32'h0, 32'hA5A5_0001, 1'b1,
                          reply(0, 0, STAT_OK, EV_NONE, 1'b0)));
    plan.push_back(op_row(CMD_ALLOC, 32'h0, 32'h1, 1'b1,
                          reply(0, 0, STAT_FULL, EV_NONE, 1'b0)));
    plan.push_back(op_row(CMD_FREE, 32'h0, 32'h0, 1'b1,
                          reply(0, 0, STAT_OK, EV_NONE, 1'b1)));
    // count saturates, size zero acts as one, base near the top of memory
    plan.push_back(cfg_row(CfgCount, 32'h3F));
    plan.push_back(cfg_row(CfgSize, 32'h0));
    plan.push_back(cfg_row(CfgBase, 32'hFFFF_FFF0));
    plan.push_back(op_row(CMD_ALLOC, 32'h0, 32'h5A5A_FFFE, 1'b0, '0));
    plan.push_back(op_row(CMD_ALLOC, 32'h0, 32'h0000_FFFF, 1'b0, '0));
    plan.push_back(op_row(CMD_ALLOC, 32'h0, 32'hDEAD_0002, 1'b0, '0));
    plan.push_back(op_row(CMD_LOOKUP, 32'h0000_000F, 32'h0, 1'b0, '0));  // wraps to slot 31
    plan.push_back(op_row(CMD_LOOKUP, 32'h0000_0010, 32'h0, 1'b0, '0));  // one past the end
    plan.push_back(op_row(CMD_LOOKUP, 32'hFFFF_FFEF, 32'h0, 1'b0, '0));  // just below base
    plan.push_back(op_row(CMD_FREE, 32'hFFFF_FFF0, 32'h0, 1'b0, '0));
    // two slots, with slot 2 still used beyond them: full, rejoin, pointer past count
    plan.push_back(cfg_row(CfgCount, 32'h2));
    plan.push_back(op_row(CMD_ALLOC, 32'h0, 32'h1234_5678, 1'b0, '0));
    plan.push_back(op_row(CMD_FREE, 32'hFFFF_FFF1, 32'h0, 1'b0, '0));
    plan.push_back(op_row(CMD_ALLOC, 32'h0, 32'h8765_4321, 1'b0, '0));
    // widest grain
    plan.push_back(cfg_row(CfgSize, 32'h01FF_FFFF));
    plan.push_back(cfg_row(CfgBase, 32'h0));
    plan.push_back(cfg_row(CfgCount, 32'd32));
    plan.push_back(op_row(CMD_ALLOC, 32'h0, 32'hFFFF_0000, 1'b0, '0));
    plan.push_back(op_row(CMD_LOOKUP, 32'h03FF_FFFE, 32'h0, 1'b0, '0));
    plan.push_back(op_row(CMD_FREE, 32'h7FFF_FFFF, 32'h0, 1'b0, '0));
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          rand_goal, j, alloc_pct, gap, sel;
    bit          quiet;
    logic [31:0] base_v, size_v, count_v;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        // registers only change with nothing in flight
        settle();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_beat(plan[i].op, plan[i].addr, plan[i].tag, plan[i].typed, plan[i].want,
                  $urandom_range(0, 16));
      end
    end

    // Random phases: new setting each phase, then a burst of traffic.
    rand_goal = n_alloc + n_free + n_lookup + RandomItems;
    while (n_alloc + n_free + n_lookup < rand_goal) begin
      settle();
      case (n_settings)
        0: begin base_v = 32'h0;         size_v = 32'h1;         count_v = 32'h1;  end
        1: begin base_v = 32'hFFFF_FFFF; size_v = 32'h01FF_FFFF; count_v = 32'd32; end
        2: begin base_v = $urandom;      size_v = 32'h0;         count_v = 32'h3F; end
        default: begin
          sel = $urandom_range(0, 3);
          base_v = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
          sel = $urandom_range(0, 7);
          size_v = (sel == 0) ? 32'h0 : (sel == 1) ? 32'h01FF_FFFF : (sel == 2) ? 32'h1 :
                   $urandom_range(2, 64);
          sel = $urandom_range(0, 7);
          count_v = (sel == 0) ? 32'h0 : (sel == 1) ? $urandom_range(33, 63) :
                    (sel == 2) ? 32'h1 : (sel == 3) ? 32'd32 : $urandom_range(2, 31);
          // bits above each register's width are don't-care
          size_v[31:SizeW]   = (32-SizeW)'($urandom);
          count_v[31:CountW] = (32-CountW)'($urandom);
        end
      endcase
      write_reg(CfgBase, base_v);
      write_reg(CfgSize, size_v);
      write_reg(CfgCount, count_v);
      n_settings++;

      sel = $urandom_range(0, 3);
      alloc_pct = (sel == 0) ? 25 : (sel == 1) ? 50 : (sel == 2) ? 75 : 90;
      quiet = 1'b0;
      for (j = 0; j < PhaseItems && n_alloc + n_free + n_lookup < rand_goal; j++) begin
        if (j % 32 == 0) quiet = ($urandom_range(0, 3) == 0);  // back-to-back stretch
        gap = quiet ? 0 : $urandom_range(0, 16);
        issue_random(alloc_pct, gap);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (owed_replies.size() != 0) note_mismatch("replies never seen", owed_replies.size(), 0);

    $display("ran %0d beats: %0d alloc, %0d free, %0d lookup, %0d unused code; %0d settings",
             n_alloc + n_free + n_lookup + n_unused, n_alloc, n_free, n_lookup, n_unused,
             n_settings + 4);
    $display("checked %0d replies, %0d chunk-full events, %0d chunk-empty frees, %0d mismatches",
             n_replies, n_fullev, n_emptied, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Reply checker: every strobe is matched against the oldest owed reply.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (done_o === 1'b1) begin
      n_replies++;
      if (owed_replies.size() == 0) begin
        note_mismatch("reply with nothing owed", slot_address_o, '0);
      end else begin
        owed_head = owed_replies.pop_front();
        if (owed_head.list_event == EV_FULL) n_fullev++;
        if (owed_head.chunk_empty) n_emptied++;
        if (slot_address_o !== owed_head.slot_address)
          note_mismatch("slot_address", slot_address_o, owed_head.slot_address);
        if (owner_out_o !== owed_head.owner)
          note_mismatch("owner_out", owner_out_o, owed_head.owner);
        if (status_o !== owed_head.status)
          note_mismatch("status", 32'(status_o), 32'(owed_head.status));
        if (list_event_o !== owed_head.list_event)
          note_mismatch("list_event", 32'(list_event_o), 32'(owed_head.list_event));
        if (chunk_empty_o !== owed_head.chunk_empty)
          note_mismatch("chunk_empty", 32'(chunk_empty_o), 32'(owed_head.chunk_empty));
      end
    end
  end

  // Watchdog: trips after too many cycles with no beat, reply or write.
  always @(posedge clk_i) begin
    if (rst_ni && ((start_i && busy_o === 1'b0) || done_o === 1'b1 || cfg_we_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("watchdog: no activity for %0d cycles, %0d replies owed",
               stall_cycles, owed_replies.size());
      $display("FAIL");
      $finish;
    end
  end

endmodule

### files.f
hdl/bsa_pkg.sv
hdl/bsa_div.sv
hdl/bsa_owner_ram.sv
hdl/bitmap_slot_allocator.sv
tb/testbench.sv
